[design/signed_fixed_point_divider_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed fixed-point divider
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_FIXED_POINT_DIVIDER_UNIT_MACROS_SVH
`define SIGNED_FIXED_POINT_DIVIDER_UNIT_MACROS_SVH

// same-cycle implication
`define SFPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sfpd_pkg.sv]
// ----------------------------------------------------------------------------
// sfpd_pkg
// Types and constants shared by the signed fixed-point divider modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpd_pkg;

	// operand and quotient width
	localparam int DataWidth = 16;

	// one request: dividend / divisor
	typedef struct packed {
		logic signed [DataWidth-1:0] dividend;
		logic signed [DataWidth-1:0] divisor;
	} req_t;

	// one result
	typedef struct packed {
		logic signed [DataWidth-1:0] quotient;
		logic                        overflow;
		logic                        divide_error;
	} rsp_t;

	// control bits that travel with a request through the divide stages
	typedef struct packed {
		logic valid;
		logic neg;
		logic zero_div;
	} ctl_t;

	// partial remainder and divisor magnitude
	typedef struct packed {
		logic [DataWidth-1:0] rem;
		logic [DataWidth-1:0] den;
	} work_t;

endpackage

`default_nettype wire

[design/sfpd_stage.sv]
// ----------------------------------------------------------------------------
// sfpd_stage
// One restoring shift-subtract step of the divider, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpd_stage #(
	parameter int NQ_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  sfpd_pkg::ctl_t    ctl_in,
	input  sfpd_pkg::work_t   work_in,
	input  logic [NQ_W-1:0]   nq_in,
	output sfpd_pkg::ctl_t    ctl_out,
	output sfpd_pkg::work_t   work_out,
	output logic [NQ_W-1:0]   nq_out
);

	localparam int W = sfpd_pkg::DataWidth;

	logic [W-1:0] trial;
	logic         ge;
	logic [W-1:0] rem_next;

	// bring down the next numerator bit, try the subtract
	// (remainder stays below a nonzero divisor, so its top bit is then zero)
	always_comb begin
		trial    = {work_in.rem[W-2:0], nq_in[NQ_W-1]};
		ge       = (trial >= work_in.den);
		rem_next = ge ? (trial - work_in.den) : trial;
	end

	// control: valid is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	// payload: numerator shifts out on top, quotient bit shifts in below
	always_ff @(posedge clk) begin
		if (en) begin
			work_out.rem <= rem_next;
			work_out.den <= work_in.den;
			nq_out       <= {nq_in[NQ_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

[design/signed_fixed_point_divider_unit.sv]
// ----------------------------------------------------------------------------
// signed_fixed_point_divider_unit
// Pipelined signed fixed-point divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries dividend and divisor,
//   two's complement with FRACTION_BITS fraction bits. Result channel
//   (rsp_valid / rsp_stall / rsp) returns quotient, overflow and divide_error.
//   A request is taken at a clock edge with valid high and stall low.
//   From request to result: one stage to strip signs, one restoring step per
//   quotient bit, one stage to apply sign and flags.
//   Throughput: one request per cycle while the result is not stalled;
//   every stage holds its own request.
//   A zero divisor gives divide_error with quotient 0; a quotient magnitude
//   of 2^15 or more gives overflow with quotient 0. A dividend of -32768
//   is taken as -32767.
//   Reset clears every valid bit; the pipe is empty afterwards.
//   While the result is stalled the whole pipe holds and req_stall is high;
//   nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_fixed_point_divider_unit #(
	parameter int FRACTION_BITS = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sfpd_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sfpd_pkg::rsp_t  rsp
);

	`include "signed_fixed_point_divider_unit_macros.svh"

	localparam int W     = sfpd_pkg::DataWidth;
	localparam int NUM_W = W - 1 + FRACTION_BITS;

	// most negative value of the quotient format
	localparam logic [W-1:0] MIN_QUOT = {1'b1, {(W-1){1'b0}}};

	logic en;

	// stage 1 registers
	sfpd_pkg::ctl_t   ctl_s1;
	sfpd_pkg::work_t  work_s1;
	logic [NUM_W-1:0] nq_s1;

	// division steps; step k sits at pipeline stage k+2
	sfpd_pkg::ctl_t   ctl_s2  [NUM_W];
	sfpd_pkg::work_t  work_s2 [NUM_W];
	logic [NUM_W-1:0] nq_s2   [NUM_W];

	// output register
	logic             rsp_valid_q;
	sfpd_pkg::rsp_t   rsp_q;

	logic [W-1:0]     ma;
	logic [W-1:0]     mb;
	logic [NUM_W-1:0] q_full;
	logic             q_hi;
	logic [W-1:0]     q_mag;
	sfpd_pkg::ctl_t   ctl_last;

	// whole pipe advances unless a held result is stalled
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	// operand magnitudes; most negative dividend clamps to max positive
	always_comb begin
		if (req.dividend == {1'b1, {(W-1){1'b0}}}) begin
			ma = {1'b0, {(W-1){1'b1}}};
		end else if (req.dividend[W-1]) begin
			ma = W'(-req.dividend);
		end else begin
			ma = req.dividend;
		end
		mb = req.divisor[W-1] ? W'(-req.divisor) : req.divisor;
	end

	// stage 1: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid    <= req_valid;
			ctl_s1.neg      <= req.dividend[W-1] ^ req.divisor[W-1];
			ctl_s1.zero_div <= (req.divisor == '0);
		end
	end

	// stage 1: payload, numerator scaled by the fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			work_s1.rem <= '0;
			work_s1.den <= mb;
			nq_s1       <= NUM_W'({ma[W-2:0], {FRACTION_BITS{1'b0}}});
		end
	end

	// restoring division chain
	generate
		for (genvar k = 0; k < NUM_W; k++) begin : g_step
			if (k == 0) begin : g_first
				sfpd_stage #(.NQ_W(NUM_W)) u_stage (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en),
					.ctl_in   (ctl_s1),
					.work_in  (work_s1),
					.nq_in    (nq_s1),
					.ctl_out  (ctl_s2[k]),
					.work_out (work_s2[k]),
					.nq_out   (nq_s2[k])
				);
			end else begin : g_next
				sfpd_stage #(.NQ_W(NUM_W)) u_stage (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en),
					.ctl_in   (ctl_s2[k-1]),
					.work_in  (work_s2[k-1]),
					.nq_in    (nq_s2[k-1]),
					.ctl_out  (ctl_s2[k]),
					.work_out (work_s2[k]),
					.nq_out   (nq_s2[k])
				);
			end
		end
	endgenerate

	assign q_full   = nq_s2[NUM_W-1];
	assign ctl_last = ctl_s2[NUM_W-1];

	// quotient bits at or above the sign position mean overflow
	generate
		if (FRACTION_BITS > 0) begin : g_ovf
			assign q_hi = |q_full[NUM_W-1:W-1];
		end else begin : g_no_ovf
			assign q_hi = 1'b0;
		end
	endgenerate

	assign q_mag = {1'b0, q_full[W-2:0]};

	// output stage: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= ctl_last.valid;
		end
	end

	// output stage: sign and flags
	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.divide_error <= ctl_last.zero_div;
			rsp_q.overflow     <= !ctl_last.zero_div && q_hi;
			if (ctl_last.zero_div || q_hi) begin
				rsp_q.quotient <= '0;
			end else if (ctl_last.neg) begin
				rsp_q.quotient <= W'(-q_mag);
			end else begin
				rsp_q.quotient <= q_mag;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`SFPD_ASSERT_NOW(a_err_clears, rsp_valid && rsp.divide_error,
		!rsp.overflow && rsp.quotient == '0, "divide error result not cleared")
	`SFPD_ASSERT_NOW(a_ovf_clears, rsp_valid && rsp.overflow,
		rsp.quotient == '0, "overflow result not zero")
	`SFPD_ASSERT_NOW(a_no_min_quot, rsp_valid,
		rsp.quotient != MIN_QUOT, "quotient hit most negative value")
	`SFPD_ASSERT_NEXT(a_req_enters, req_valid && !req_stall,
		ctl_s1.valid, "accepted request lost at stage 1")

endmodule

`default_nettype wire
